// ===== design/fhfe_pkg.sv =====
package fhfe_pkg;

  // input item: one frame byte and its end marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  // result item for one frame byte
  typedef struct packed {
    logic [7:0]  value_byte;
    logic [2:0]  field_code;
    logic        value_valid;
    logic        field_done;
    logic        frame_done;
    logic [31:0] seq_number;
  } out_item_t;

  // field codes of the recognized header tags
  typedef enum logic [2:0] {
    FLD_NONE   = 3'd0,
    FLD_BEGIN  = 3'd1,
    FLD_SEQ    = 3'd2,
    FLD_SENDER = 3'd3,
    FLD_TARGET = 3'd4
  } field_e;

  // per-item controls for the sequence number parser
  typedef struct packed {
    logic start;
    logic take;
    logic clear;
  } seq_ctrl_t;

  localparam logic [7:0]  SohByte      = 8'h01;
  localparam logic [7:0]  EqByte       = 8'h3D;
  localparam logic [7:0]  DigitZero    = 8'h30;
  localparam logic [7:0]  DigitNine    = 8'h39;
  localparam logic [31:0] SeqLimit     = 32'd429496729;
  localparam logic [3:0]  SeqLastDigit = 4'd5;

  localparam logic [31:0] TagBegin  = 32'd8;
  localparam logic [31:0] TagSeq    = 32'd34;
  localparam logic [31:0] TagSender = 32'd49;
  localparam logic [31:0] TagTarget = 32'd56;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= DigitZero) && (b <= DigitNine);
  endfunction

  function automatic field_e code_of_tag(input logic [31:0] t);
    case (t)
      TagBegin:  code_of_tag = FLD_BEGIN;
      TagSeq:    code_of_tag = FLD_SEQ;
      TagSender: code_of_tag = FLD_SENDER;
      TagTarget: code_of_tag = FLD_TARGET;
      default:   code_of_tag = FLD_NONE;
    endcase
  endfunction

endpackage

// ===== design/fhfe_seq_parse.sv =====
module fhfe_seq_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fhfe_pkg::seq_ctrl_t ctrl_i,
  input  logic [7:0]         data_i,
  output logic [31:0]        seq_number_o
);
  import fhfe_pkg::*;

  logic [31:0] accum_q, accum_d;
  logic        seen_q, seen_d;
  logic        invalid_q, invalid_d;
  logic        empty_q, empty_d;
  logic [3:0]  digit;

  assign digit = 4'(data_i - DigitZero);

  // next parser state for this item
  always_comb begin
    accum_d   = accum_q;
    seen_d    = seen_q;
    invalid_d = invalid_q;
    empty_d   = empty_q;
    if (ctrl_i.start) begin
      seen_d    = 1'b1;
      empty_d   = 1'b1;
      invalid_d = 1'b0;
      accum_d   = '0;
    end else if (ctrl_i.take) begin
      empty_d = 1'b0;
      if (!invalid_q) begin
        if (!is_digit(data_i)) begin
          invalid_d = 1'b1;
        end else if ((accum_q > SeqLimit) ||
                     ((accum_q == SeqLimit) && (digit > SeqLastDigit))) begin
          invalid_d = 1'b1;
        end else begin
          accum_d = (accum_q << 3) + (accum_q << 1) + {28'd0, digit};
        end
      end
    end
  end

  // number as it stands after this item
  assign seq_number_o = (seen_d && !empty_d && !invalid_d) ? accum_d : '0;

  // parser registers, cleared at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q   <= '0;
      seen_q    <= 1'b0;
      invalid_q <= 1'b0;
      empty_q   <= 1'b1;
    end else if (ctrl_i.clear) begin
      accum_q   <= '0;
      seen_q    <= 1'b0;
      invalid_q <= 1'b0;
      empty_q   <= 1'b1;
    end else begin
      accum_q   <= accum_d;
      seen_q    <= seen_d;
      invalid_q <= invalid_d;
      empty_q   <= empty_d;
    end
  end

endmodule

// ===== design/fix_header_field_extractor.sv =====
// result: the result of each accepted item is registered in the output register
// throughput: one item per cycle; the next byte is taken while a result waits,
//   as long as the output register is empty or being drained in the same cycle
// reset: asynchronous active low; returns the scanner to the tag phase, clears
//   the sequence number parser and empties the output register
module fix_header_field_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fhfe_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fhfe_pkg::out_item_t out_item_o
);
  import fhfe_pkg::*;

  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] tag_q, tag_d;
  logic        tag_ok_q, tag_ok_d;
  field_e      field_q, field_d;
  logic        out_valid_q;
  out_item_t   out_q, out_d, res;
  seq_ctrl_t   seq_ctrl;
  logic [31:0] seq_num;
  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic        restart;

  assign b          = in_item_i.data_byte;
  assign last       = in_item_i.frame_last;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // byte scanner
  always_comb begin
    phase_d        = phase_q;
    tag_d          = tag_q;
    tag_ok_d       = tag_ok_q;
    field_d        = field_q;
    restart        = 1'b0;
    res            = '0;
    seq_ctrl       = '0;
    unique case (phase_q)
      PH_VALUE: begin
        if (b == SohByte) begin
          res.field_done = (field_q != FLD_NONE);
          res.field_code = field_q;
          restart        = 1'b1;
        end else begin
          if (field_q != FLD_NONE) begin
            res.value_valid = 1'b1;
            res.value_byte  = b;
            res.field_code  = field_q;
            res.field_done  = last;
          end
          seq_ctrl.take = (field_q == FLD_SEQ);
        end
      end
      PH_SKIP: begin
        restart = (b == SohByte);
      end
      default: begin
        if (b == EqByte) begin
          if (tag_ok_q) begin
            field_d        = code_of_tag(tag_q);
            phase_d        = PH_VALUE;
            seq_ctrl.start = (field_d == FLD_SEQ);
            if (last && (field_d != FLD_NONE)) begin
              res.field_done = 1'b1;
              res.field_code = field_d;
            end
          end else begin
            phase_d = PH_SKIP;
          end
        end else if (b == SohByte) begin
          restart = 1'b1;
        end else begin
          if (!is_digit(b)) begin
            tag_ok_d = 1'b0;
          end
          tag_d = (tag_q << 3) + (tag_q << 1) + {24'd0, b} - {24'd0, DigitZero};
        end
      end
    endcase
    // a field ends or the frame ends: back to the tag phase
    if (restart || last) begin
      phase_d  = PH_TAG;
      tag_d    = '0;
      tag_ok_d = 1'b1;
      field_d  = FLD_NONE;
    end
    seq_ctrl.clear  = last;
    res.frame_done  = last;
    seq_ctrl.start  = seq_ctrl.start && accept;
    seq_ctrl.take   = seq_ctrl.take && accept;
    seq_ctrl.clear  = seq_ctrl.clear && accept;
  end

  fhfe_seq_parse u_seq_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (seq_ctrl),
    .data_i       (b),
    .seq_number_o (seq_num)
  );

  // result with the sequence number on the frame's last byte
  always_comb begin
    out_d            = res;
    out_d.seq_number = last ? seq_num : '0;
  end

  // scanner state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      tag_q       <= '0;
      tag_ok_q    <= 1'b1;
      field_q     <= FLD_NONE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        tag_q    <= tag_d;
        tag_ok_q <= tag_ok_d;
        field_q  <= field_d;
        out_q    <= out_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // assertions
  a_seq_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.frame_done |-> out_item_o.seq_number == '0)
    else $error("sequence number outside frame end");

  a_code_with_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.value_valid || out_item_o.field_done)
      |-> out_item_o.field_code != FLD_NONE)
    else $error("field flag without field code");

  a_frame_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> phase_q == PH_TAG && field_q == FLD_NONE && tag_q == '0)
    else $error("scanner not restarted after frame end");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed");

endmodule
